// ----- sv/hds_pkg.sv -----
// Shared types and constants for the response-ratio dispatch selector.
// Depends on nothing; used by the multiplier and the top level.
package hds_pkg;

  localparam int unsigned ClkW = 32;
  localparam int unsigned SvcW = 16;
  localparam int unsigned IdW  = 16;
  localparam int unsigned PriW = 8;
  localparam int unsigned ProdW = ClkW + SvcW;

  localparam logic [ClkW-1:0] ClkMax = {ClkW{1'b1}};

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_DISP = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  // Status codes carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ZERO  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // One table entry, identifier in the low bits.
  typedef struct packed {
    logic [ClkW-1:0] arrival;
    logic [SvcW-1:0] service;
    logic [PriW-1:0] prio;
    logic [IdW-1:0]  id;
  } job_t;

endpackage

// ----- sv/hds_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module hds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth>1?$clog2(Depth):1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth>1?$clog2(Depth):1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/hds_mul.sv -----
// Shared 32 by 16 bit unsigned multiplier with a registered product.
// Depends on hds_pkg for the operand widths.
module hds_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [hds_pkg::ClkW-1:0]    a_i,
  input  logic [hds_pkg::SvcW-1:0]    b_i,
  output logic [hds_pkg::ProdW-1:0]   p_o
);

  logic [hds_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= hds_pkg::ProdW'(a_i) * hds_pkg::ProdW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ----- sv/hrrn_dispatch_selector.sv -----
// Top level of the highest-response-ratio-next dispatch selector.
// Depends on hds_pkg, hds_ram (job table) and hds_mul (shared multiplier).
// Usage. Items arrive on the slave stream: s_axis_tuser carries the operation
// (add job, arrival tick, dispatch request) and s_axis_tdata the job fields.
// Every accepted transfer produces exactly one result transfer on the master
// stream: m_axis_tuser carries the status and m_axis_tdata the chosen job.
// Add and tick items go straight to S_FIN, which loads the result register.
// A dispatch reads the table through one memory port, takes the oldest entry
// as the first candidate and judges each later arrived job against the best
// so far with the single shared multiplier; a job not yet arrived ends the
// scan. Then each entry above the pick is copied one place down to close the
// gap, and S_DONE updates the count and the run clock before S_FIN loads the
// result register. The sequencer works on one item at a time, and
// s_axis_tready is high only while it is idle.
// The result sits in an output register, so the block takes the next item
// while a finished result still waits; only when a second result is ready
// before the receiver has taken the first does the sequencer hold it.
// Reset empties the table and sets both clocks to one; the table contents
// themselves are not cleared, as entries above the fill count are never read.
module hrrn_dispatch_selector #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // job_id [15:0], job_priority [23:16],
                                     // service_time [39:24]
  input  logic [1:0]  s_axis_tuser,  // operation [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // chosen_id [15:0], chosen_priority [23:16],
                                     // chosen_service [39:24], chosen_wait [71:40]
  output logic [1:0]  m_axis_tuser   // status [1:0]
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(hds_pkg::job_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_MUL,
    S_CMP,
    S_MVRD,
    S_MVWR,
    S_DONE,
    S_FIN
  } state_e;

  state_e state_q;

  logic [CW-1:0]                count_q;
  logic [CW-1:0]                idx_q;
  logic [CW-1:0]                best_idx_q;
  logic [hds_pkg::ClkW-1:0]     arr_clk_q;
  logic [hds_pkg::ClkW-1:0]     run_clk_q;
  logic [hds_pkg::ClkW-1:0]     best_wait_q;
  logic [hds_pkg::ClkW-1:0]     wait_q;
  logic [hds_pkg::ProdW-1:0]    rhs_q;
  hds_pkg::job_t                best_q;

  // Pending result and output register.
  hds_pkg::status_e             res_status_q;
  hds_pkg::job_t                res_job_q;
  logic [hds_pkg::ClkW-1:0]     res_wait_q;
  logic                         m_valid_q;
  logic [1:0]                   m_user_q;
  logic [71:0]                  m_data_q;

  // Memory and multiplier hookup.
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  hds_pkg::job_t                ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [EW-1:0]                ram_rdata;
  hds_pkg::job_t                rd_job;
  logic                         mul_en;
  logic [hds_pkg::ClkW-1:0]     mul_a;
  logic [hds_pkg::SvcW-1:0]     mul_b;
  logic [hds_pkg::ProdW-1:0]    mul_p;

  // Input fields.
  logic                         s_acc;
  hds_pkg::op_e                 in_op;
  logic [hds_pkg::IdW-1:0]      in_id;
  logic [hds_pkg::PriW-1:0]     in_pri;
  logic [hds_pkg::SvcW-1:0]     in_svc;
  logic                         add_ok;

  logic [CW-1:0]                idx_inc;
  logic                         more;
  logic                         better;
  logic                         not_arrived;
  logic [hds_pkg::ClkW:0]       run_sum;
  logic [hds_pkg::ClkW-1:0]     run_next;
  logic                         out_free;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign in_op   = hds_pkg::op_e'(s_axis_tuser);
  assign in_id   = s_axis_tdata[15:0];
  assign in_pri  = s_axis_tdata[23:16];
  assign in_svc  = s_axis_tdata[39:24];
  assign add_ok  = (in_svc != '0) && (count_q < CW'(TABLE_DEPTH));

  assign rd_job      = hds_pkg::job_t'(ram_rdata);
  assign idx_inc     = idx_q + CW'(1);
  assign more        = (idx_inc < count_q);
  assign not_arrived = (rd_job.arrival > run_clk_q);
  // Strictly greater only, so ties keep the earlier inserted job.
  assign better      = (mul_p > rhs_q);

  assign run_sum  = {1'b0, run_clk_q} + (hds_pkg::ClkW + 1)'(best_q.service);
  assign run_next = run_sum[hds_pkg::ClkW] ? hds_pkg::ClkMax : run_sum[hds_pkg::ClkW-1:0];
  assign out_free = !m_valid_q || m_axis_tready;

  // Table port control: new jobs are appended at the fill count, and during
  // compaction each entry is copied one place down.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = '{arrival: arr_clk_q, service: in_svc, prio: in_pri, id: in_id};
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        ram_we = s_acc && (in_op == hds_pkg::OP_ADD) && add_ok;
      end
      S_RD: begin
        ram_re = 1'b1;
      end
      S_MVRD: begin
        ram_re    = more;
        ram_raddr = idx_inc[AW-1:0];
      end
      S_MVWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = rd_job;
      end
      default: begin
      end
    endcase
  end

  // The multiplier first forms best_wait * service(i), then wait(i) * service(best).
  always_comb begin
    mul_en = 1'b0;
    mul_a  = best_wait_q;
    mul_b  = rd_job.service;
    case (state_q)
      S_CHK: begin
        mul_en = (idx_q != '0) && !not_arrived;
      end
      S_MUL: begin
        mul_en = 1'b1;
        mul_a  = wait_q;
        mul_b  = best_q.service;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      arr_clk_q    <= hds_pkg::ClkW'(1);
      run_clk_q    <= hds_pkg::ClkW'(1);
      m_valid_q    <= 1'b0;
      idx_q        <= '0;
      best_idx_q   <= '0;
    end else begin
      // A new result in S_FIN reloads the register itself.
      if (m_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            res_job_q  <= '0;
            res_wait_q <= '0;
            case (in_op)
              hds_pkg::OP_ADD: begin
                state_q <= S_FIN;
                if (in_svc == '0) begin
                  res_status_q <= hds_pkg::ST_ZERO;
                end else if (!add_ok) begin
                  res_status_q <= hds_pkg::ST_FULL;
                end else begin
                  res_status_q <= hds_pkg::ST_OK;
                  count_q      <= count_q + CW'(1);
                end
              end
              hds_pkg::OP_TICK: begin
                state_q      <= S_FIN;
                res_status_q <= hds_pkg::ST_OK;
                if (arr_clk_q != hds_pkg::ClkMax) begin
                  arr_clk_q <= arr_clk_q + hds_pkg::ClkW'(1);
                end
              end
              hds_pkg::OP_DISP: begin
                if (count_q == '0) begin
                  res_status_q <= hds_pkg::ST_EMPTY;
                  state_q      <= S_FIN;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_RD;
                end
              end
              default: begin
                res_status_q <= hds_pkg::ST_OK;
                state_q      <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (idx_q == '0) begin
            // The oldest job is the first candidate, or the fallback when
            // nothing has arrived yet.
            best_idx_q <= '0;
            best_q     <= rd_job;
            if (not_arrived) begin
              best_wait_q <= '0;
              state_q     <= S_MVRD;
            end else begin
              best_wait_q <= run_clk_q - rd_job.arrival;
              if (more) begin
                idx_q   <= idx_inc;
                state_q <= S_RD;
              end else begin
                state_q <= S_MVRD;
              end
            end
          end else if (not_arrived) begin
            // Arrival ticks grow with insertion order, so the scan stops here.
            idx_q   <= best_idx_q;
            state_q <= S_MVRD;
          end else begin
            wait_q  <= run_clk_q - rd_job.arrival;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          rhs_q   <= mul_p;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (better) begin
            best_idx_q  <= idx_q;
            best_q      <= rd_job;
            best_wait_q <= wait_q;
          end
          if (more) begin
            idx_q   <= idx_inc;
            state_q <= S_RD;
          end else begin
            idx_q   <= better ? idx_q : best_idx_q;
            state_q <= S_MVRD;
          end
        end
        S_MVRD: begin
          state_q <= more ? S_MVWR : S_DONE;
        end
        S_MVWR: begin
          idx_q   <= idx_inc;
          state_q <= S_MVRD;
        end
        S_DONE: begin
          count_q      <= count_q - CW'(1);
          run_clk_q    <= run_next;
          res_status_q <= hds_pkg::ST_OK;
          res_job_q    <= best_q;
          res_wait_q   <= best_wait_q;
          state_q      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_status_q;
            m_data_q  <= {res_wait_q, res_job_q.service, res_job_q.prio, res_job_q.id};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  hds_ram #(
    .Width(EW),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  hds_mul u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("job count exceeds table depth");

  a_run_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> run_clk_q >= $past(run_clk_q))
    else $error("run clock went backwards");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && in_op == hds_pkg::OP_ADD && add_ok) |=> count_q == $past(count_q) + CW'(1))
    else $error("accepted job not counted");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_CHK || state_q == S_MUL || state_q == S_CMP)
      |-> !ram_we)
    else $error("table written during scan");
`endif

endmodule

// ----- tb/tb_hrrn_dispatch_selector.sv -----
// Self-checking testbench for the response-ratio dispatch selector: random and directed
// job streams, with a scoreboard class that predicts every result transfer.
// Depends on hds_pkg and hrrn_dispatch_selector.
module tb_hrrn_dispatch_selector;

  localparam int unsigned Depth     = 16;
  localparam int unsigned QuietMax  = 4000;  // cycles without any transfer before giving up
  localparam int unsigned LongHold  = 300;   // receiver hold-off that fills the block
  localparam int unsigned RandItems = 800;

  // One waiting job as the scoreboard keeps it.
  typedef struct {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] service;
    logic [31:0] arrival;
  } job_rec_t;

  // One result transfer, field by field.
  typedef struct {
    hds_pkg::status_e status;
    logic [15:0]      id;
    logic [7:0]       prio;
    logic [15:0]      service;
    logic [31:0]      waited;
  } outcome_t;

  // Scoreboard: mirrors the job table and both clocks, and holds the outcomes still owed.
  class dispatch_tracker;
    job_rec_t    jobs[Depth];
    int unsigned n_jobs;
    logic [31:0] arrival_clk;
    logic [31:0] run_clk;
    outcome_t    owed[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      n_jobs      = 0;
      arrival_clk = 1;
      run_clk     = 1;
      errors      = 0;
      checked     = 0;
    endfunction

    // Both clocks stick at their maximum instead of wrapping.
    function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? hds_pkg::ClkMax : sum[31:0];
    endfunction

    function outcome_t dispatch_outcome(hds_pkg::op_e op, logic [15:0] id,
                                        logic [7:0] prio, logic [15:0] svc);
      outcome_t    res;
      job_rec_t    pick;
      int unsigned best;
      int unsigned i;
      logic [31:0] best_wait;
      logic [31:0] w;
      logic [47:0] lhs;
      logic [47:0] rhs;
      res = '{status: hds_pkg::ST_OK, id: '0, prio: '0, service: '0, waited: '0};
      case (op)
        hds_pkg::OP_ADD: begin
          // A zero service time is rejected before the fill level is looked at.
          if (svc == '0) begin
            res.status = hds_pkg::ST_ZERO;
          end else if (n_jobs >= Depth) begin
            res.status = hds_pkg::ST_FULL;
          end else begin
            jobs[n_jobs] = '{id: id, prio: prio, service: svc, arrival: arrival_clk};
            n_jobs++;
          end
        end
        hds_pkg::OP_TICK: begin
          arrival_clk = sat_add(arrival_clk, 32'd1);
        end
        hds_pkg::OP_DISP: begin
          if (n_jobs == 0) begin
            res.status = hds_pkg::ST_EMPTY;
          end else begin
            best      = 0;
            best_wait = '0;
            // Jobs sit in arrival order, so the scan stops at the first one still to come.
            // When even the oldest has not arrived, it is taken with a wait of zero.
            if (jobs[0].arrival <= run_clk) begin
              best_wait = run_clk - jobs[0].arrival;
              for (i = 1; i < n_jobs; i++) begin
                if (jobs[i].arrival > run_clk) break;
                w   = run_clk - jobs[i].arrival;
                lhs = 48'(w) * 48'(jobs[best].service);
                rhs = 48'(best_wait) * 48'(jobs[i].service);
                // Strictly greater only, so the earlier job keeps a tie.
                if (lhs > rhs) begin
                  best      = i;
                  best_wait = w;
                end
              end
            end
            pick = jobs[best];
            for (i = best; i + 1 < n_jobs; i++) jobs[i] = jobs[i + 1];
            n_jobs--;
            run_clk     = sat_add(run_clk, {16'b0, pick.service});
            res.id      = pick.id;
            res.prio    = pick.prio;
            res.service = pick.service;
            res.waited  = best_wait;
          end
        end
        default: begin
          // The spare operation code changes nothing and reports all zeros.
        end
      endcase
      return res;
    endfunction

    function void note_item(hds_pkg::op_e op, logic [39:0] data);
      owed.push_back(dispatch_outcome(op, data[15:0], data[23:16], data[39:24]));
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] user, logic [71:0] data);
      outcome_t want;
      checked++;
      if (owed.size() == 0) begin
        $error("result transfer with nothing outstanding: status %0d data %h", user, data);
        errors++;
      end else begin
        want = owed.pop_front();
        compare_field("status", want.status, user);
        compare_field("chosen_id", want.id, data[15:0]);
        compare_field("chosen_priority", want.prio, data[23:16]);
        compare_field("chosen_service", want.service, data[39:24]);
        compare_field("chosen_wait", want.waited, data[71:40]);
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // job_id [15:0], job_priority [23:16], service_time [39:24]
  logic [1:0]  s_axis_tuser  = hds_pkg::OP_NOP;  // operation [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;  // chosen_id [15:0], chosen_priority [23:16],
                              // chosen_service [39:24], chosen_wait [71:40]
  logic [1:0]  m_axis_tuser;  // status [1:0]

  dispatch_tracker tracker = new();
  int unsigned     tx_calm = 0;
  int unsigned     rx_calm = 0;

  always #2 clk_i = ~clk_i;

  hrrn_dispatch_selector #(
    .TABLE_DEPTH(Depth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Idle lengths: mostly none or short, now and then long, with calm stretches of none.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(30, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Early on services stay small so that the arrival clock can keep up with the run
  // clock; later the whole range is used.
  function automatic logic [15:0] pick_service(bit wide);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (!wide) return 16'($urandom_range(1, 6));
    if (r < 10) return 16'hFFFF;
    if (r < 40) return 16'($urandom);
    return 16'($urandom_range(1, 6));
  endfunction

  // Offers one item, waits for the edge that takes it, then idles for a random gap. The valid
  // is only lowered when a gap follows, so it never sees two assignments in one time step.
  task automatic offer_item(hds_pkg::op_e op, logic [15:0] id, logic [7:0] prio,
                            logic [15:0] svc);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {svc, prio, id};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_directed();
    int unsigned k;
    offer_item(hds_pkg::OP_DISP, 16'h0000, 8'h00, 16'h0000);  // dispatch from an empty table
    offer_item(hds_pkg::OP_ADD, 16'hFFFF, 8'hFF, 16'h0000);   // zero service is refused
    offer_item(hds_pkg::OP_NOP, 16'hFFFF, 8'hFF, 16'hFFFF);   // spare code, ignored
    offer_item(hds_pkg::OP_TICK, 16'h0000, 8'h00, 16'h0000);
    // Both jobs arrive after the run clock, so the oldest goes with a wait of zero.
    offer_item(hds_pkg::OP_ADD, 16'h1234, 8'h5A, 16'd3);
    offer_item(hds_pkg::OP_ADD, 16'h4321, 8'hA5, 16'd2);
    offer_item(hds_pkg::OP_DISP, 16'h0000, 8'h00, 16'h0000);
    // Equal ratios: the earlier of the two must win.
    offer_item(hds_pkg::OP_ADD, 16'h0000, 8'h00, 16'd2);
    offer_item(hds_pkg::OP_DISP, 16'h0000, 8'h00, 16'h0000);
    for (k = 0; k < Depth - 1; k++) begin
      offer_item(hds_pkg::OP_ADD, 16'($urandom), 8'($urandom), 16'($urandom_range(1, 4)));
    end
    // Table now full: an ordinary add is refused, a zero-service add reports that first.
    offer_item(hds_pkg::OP_ADD, 16'hFFFF, 8'hFF, 16'hFFFF);
    offer_item(hds_pkg::OP_ADD, 16'hFFFF, 8'hFF, 16'h0000);
  endtask

  // Random part: bursts of adds with ticks between them, bursts of dispatches, runs of
  // ticks, and a little noise with any operation code.
  task automatic run_random();
    int unsigned  counted;
    int unsigned  r;
    int unsigned  n;
    int unsigned  t;
    int unsigned  k;
    bit           wide;
    hds_pkg::op_e op;
    counted = 0;
    while (counted < RandItems) begin
      wide = counted >= (RandItems * 7) / 10;
      r    = $urandom_range(0, 19);
      if (r < 8) begin
        n = $urandom_range(1, Depth + 1);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 1) == 1) begin
            t = $urandom_range(1, 6);
            repeat (t) begin
              offer_item(hds_pkg::OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
            end
            counted += t;
          end
          offer_item(hds_pkg::OP_ADD, 16'($urandom), 8'($urandom), pick_service(wide));
          counted++;
        end
      end else if (r < 15) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          offer_item(hds_pkg::OP_DISP, 16'($urandom), 8'($urandom), 16'($urandom));
        end
        counted += n;
      end else if (r < 18) begin
        n = $urandom_range(1, 40);
        repeat (n) begin
          offer_item(hds_pkg::OP_TICK, 16'($urandom), 8'($urandom), 16'($urandom));
        end
        counted += n;
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          op = hds_pkg::op_e'(2'($urandom_range(0, 3)));
          offer_item(op, 16'($urandom), 8'($urandom), 16'($urandom));
          if (op != hds_pkg::OP_NOP) counted++;
        end
      end
    end
  endtask

  // Both streams are observed at the clock edge, before any of this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_item(hds_pkg::op_e'(s_axis_tuser), s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Receiver: random back-pressure, plus two long hold-offs while items keep coming, so
  // that a finished result waits in the output register and the input stalls behind it.
  initial begin
    int unsigned busy;
    int unsigned hold;
    int unsigned holds_done;
    holds_done = 0;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      busy = $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (busy) @(posedge clk_i);
      hold = pick_gap(rx_calm);
      if (holds_done < 2 && tracker.checked >= (holds_done == 0 ? 150 : 500)) begin
        hold = LongHold;
        holds_done++;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Watchdog: gives up after a long run of cycles in which neither side transfers.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietMax) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("hrrn_dispatch_selector: mismatch");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk_i);
    // This closing wait outlasts a full-table dispatch; any stray transfer in this
    // window is caught as unexpected.
    repeat (200) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("hrrn_dispatch_selector: match");
    end else begin
      $display("hrrn_dispatch_selector: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hds_pkg.sv
sv/hds_ram.sv
sv/hds_mul.sv
sv/hrrn_dispatch_selector.sv
tb/tb_hrrn_dispatch_selector.sv
